/* rtl/fnvh_pkg.sv */
// Shared types, constants and the prime multiply for the FNV-1a word hasher.
package fnvh_pkg;

	localparam logic [63:0] OffsetBasis = 64'hCBF2_9CE4_8422_2325;
	localparam logic [63:0] NegZeroBits = 64'h8000_0000_0000_0000;
	localparam int unsigned ByteBits  = 8;
	localparam int unsigned WordBytes = 8;
	localparam int unsigned CntW      = $clog2(WordBytes);

	// Configuration register indexes.
	localparam int unsigned CfgIdxW = 1;
	localparam logic [CfgIdxW-1:0] CfgStartHash = 1'b0;
	localparam logic [CfgIdxW-1:0] CfgRemapZero = 1'b1;

	typedef struct packed {
		logic [63:0] data_word;
		logic        is_double;
		logic        first_word;
		logic        last_word;
		logic        abort_run;
	} fnvh_in_t;

	typedef struct packed {
		logic [63:0] fingerprint;
		logic        failed;
	} fnvh_out_t;

	// Commands from the control logic to the byte engine.
	typedef struct packed {
		logic start;
		logic reload;
	} fnvh_ctrl_t;

	// Status from the byte engine.
	typedef struct packed {
		logic busy;
		logic last_step;
	} fnvh_sts_t;

	// Multiply by the prime 0x100000001B3 modulo 2^64: 2^40 plus 0x1B3,
	// and 0x1B3 is bits 8, 7, 5, 4, 1 and 0.
	function automatic logic [63:0] fnv_mul_prime(input logic [63:0] h);
		return (h << 40) + (h << 8) + (h << 7) + (h << 5) + (h << 4) + (h << 1) + h;
	endfunction

endpackage

/* rtl/fnvh_byte_engine.sv */
// Byte-serial FNV-1a absorber: one byte of the word per cycle into the running hash.
module fnvh_byte_engine
	import fnvh_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  fnvh_ctrl_t  ctrl,
	input  logic [63:0] word,
	input  logic [63:0] seed,
	output fnvh_sts_t   sts,
	output logic [63:0] hash
);

	logic [63:0]     word_q;
	logic [63:0]     hash_q;
	logic [CntW-1:0] cnt_q;
	logic            running_q;
	logic [63:0]     h_mix;
	logic [63:0]     h_next;

	// XOR the low byte of the shifting word in, then multiply by the prime.
	assign h_mix  = hash_q ^ {{(64 - ByteBits){1'b0}}, word_q[ByteBits-1:0]};
	assign h_next = fnv_mul_prime(h_mix);

	assign sts.busy      = running_q;
	assign sts.last_step = running_q && (cnt_q == CntW'(WordBytes - 1));
	assign hash          = hash_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			cnt_q     <= '0;
			hash_q    <= OffsetBasis;
		end else begin
			if (ctrl.reload) begin
				hash_q <= seed;
			end else if (running_q) begin
				hash_q <= h_next;
			end
			if (ctrl.start) begin
				running_q <= 1'b1;
				cnt_q     <= '0;
			end else if (running_q) begin
				cnt_q <= cnt_q + CntW'(1);
				if (sts.last_step) begin
					running_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			word_q <= word;
		end else if (running_q) begin
			word_q <= word_q >> ByteBits;
		end
	end

endmodule

/* rtl/fnv1a64_word_stream_hasher_unit.sv */
// Top level of the streaming FNV-1a 64-bit word hasher.
// Results: a last word's result passes from the byte engine through the emit state into the
//   output register, and an abort's failed result passes through the emit state into it.
// Flow: one byte of a word per cycle through the engine's shift register and prime multiply;
//   the next word enters on a plain word's final byte step, else once the result is placed.
// Reset: start_hash and the running hash go to the offset basis, remap_zero to 1,
//   the output register is emptied.
module fnv1a64_word_stream_hasher_unit
	import fnvh_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	// Input channel.
	input  logic               in_valid,
	output logic               in_stall,
	input  fnvh_in_t           in_data,
	// Output channel.
	output logic               out_valid,
	input  logic               out_stall,
	output fnvh_out_t          out_data,
	// Configuration write port.
	input  logic               cfg_we,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [63:0]        cfg_data
);

	// The controller is idle, absorbing a word, or waiting to place a result.
	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_EMIT = 3'b100
	} state_t;

	state_t      state_q;
	state_t      state_d;
	logic [63:0] start_hash_q;
	logic        remap_zero_q;
	logic        emit_pend_q;
	logic        fail_q;
	logic        out_valid_q;
	fnvh_out_t   out_q;

	fnvh_ctrl_t  ctrl;
	fnvh_sts_t   sts;
	logic [63:0] hash;
	logic [63:0] canon_word;
	logic        in_xfer;
	logic        out_free;
	logic        emit;
	logic [63:0] final_hash;

	// Configuration registers. The user must write them only while the block is idle; the block does not enforce it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_hash_q <= OffsetBasis;
			remap_zero_q <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CfgStartHash: start_hash_q <= cfg_data;
				CfgRemapZero: remap_zero_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// A new word may enter while idle, or on the engine's final byte step when that
	// word has no result to place, so back-to-back plain words run at one byte per cycle.
	assign in_stall = !((state_q == ST_IDLE) ||
		((state_q == ST_RUN) && sts.last_step && !emit_pend_q));
	assign in_xfer  = in_valid && !in_stall;

	// A double holding negative zero hashes as positive zero.
	assign canon_word = (in_data.is_double && (in_data.data_word == NegZeroBits)) ?
		64'd0 : in_data.data_word;

	// An abort does not absorb its word; it only reloads the hash from start_hash.
	always_comb begin
		ctrl.start  = in_xfer && !in_data.abort_run;
		ctrl.reload = in_xfer && (in_data.abort_run || in_data.first_word);
	end

	fnvh_byte_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.word   (canon_word),
		.seed   (start_hash_q),
		.sts    (sts),
		.hash   (hash)
	);

	// The output register takes a new result when it is empty or its current
	// result leaves in this same cycle.
	assign out_free = !out_valid_q || !out_stall;
	assign emit     = (state_q == ST_EMIT) && out_free;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					state_d = in_data.abort_run ? ST_EMIT : ST_RUN;
				end
			end
			ST_RUN: begin
				if (in_xfer) begin
					state_d = in_data.abort_run ? ST_EMIT : ST_RUN;
				end else if (sts.last_step) begin
					state_d = emit_pend_q ? ST_EMIT : ST_IDLE;
				end
			end
			ST_EMIT: begin
				if (emit) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			emit_pend_q <= 1'b0;
			fail_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_xfer) begin
				emit_pend_q <= in_data.last_word && !in_data.abort_run;
				fail_q      <= in_data.abort_run;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// The zero remap touches only the reported value, never the running hash.
	assign final_hash = ((hash == 64'd0) && remap_zero_q) ? 64'd1 : hash;

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q.fingerprint <= fail_q ? 64'd0 : final_hash;
			out_q.failed      <= fail_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

/* rtl/fnvh_checker.sv */
// Port-level checker for the FNV-1a word hasher, bound to the top level.
module fnvh_checker
	import fnvh_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input fnvh_in_t           in_data,
	input logic               out_valid,
	input logic               out_stall,
	input fnvh_out_t          out_data,
	input logic               cfg_we,
	input logic [CfgIdxW-1:0] cfg_index,
	input logic [63:0]        cfg_data
);

	logic in_xfer;
	assign in_xfer = in_valid && !in_stall;

	// A failed result always carries a zero fingerprint.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.failed |-> out_data.fingerprint == 64'd0)
		else $error("failed result with nonzero fingerprint");

	// A word being absorbed holds off the next one through each of its byte steps but the last.
	a_word_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && !in_data.abort_run |=> in_stall ##1 in_stall ##1 in_stall ##1 in_stall
		##1 in_stall ##1 in_stall ##1 in_stall)
		else $error("word accepted before the previous word was absorbed");

	// An abort's transfer is followed by a stall of the input, while its result is pending.
	a_abort_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && in_data.abort_run |=> in_stall)
		else $error("input taken while an abort result was pending");

	// A stalled result stays in place.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed or vanished");

endmodule

bind fnv1a64_word_stream_hasher_unit fnvh_checker u_fnvh_checker (.*);
